// ===== rtl/core/spherical_bessel_low_order_unit_defines.svh =====
// assertion macros for the spherical bessel unit
`ifndef SPHERICAL_BESSEL_LOW_ORDER_UNIT_DEFINES_SVH
`define SPHERICAL_BESSEL_LOW_ORDER_UNIT_DEFINES_SVH

// same-cycle implication
`define SBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define SBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/sbl_pkg.sv =====
// types, constants and step programme for the spherical bessel unit
package sbl_pkg;

    localparam int IN_FRAC_BITS_DEF  = 16;
    localparam int RES_FRAC_BITS_DEF = 30;

    localparam logic [63:0] ONE_Q60        = 64'h1000_0000_0000_0000;
    localparam logic [63:0] FOUR_Q60       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] HALF_PI_Q62    = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] X_ZERO_LIMIT   = 64'd43;
    localparam logic [63:0] X_CUT5         = 64'd601295422;
    localparam logic [63:0] X_CUT6         = 64'd1245540516;
    localparam logic [63:0] X_SERIES_LIMIT = 64'h0000_0004_0000_0000;
    localparam logic [63:0] X_RECIP_MIN    = 64'h0000_0000_2000_0000;

    localparam int RCP_STEPS     = 93;
    localparam int RCP_PER_STAGE = 2;
    localparam int RCP_STAGES    = (RCP_STEPS + RCP_PER_STAGE - 1) / RCP_PER_STAGE;

    localparam int STEP_LAT     = 6;
    localparam int SERIES_TERMS = 30;
    localparam int NUM_STEPS    = 37 + SERIES_TERMS;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    localparam logic [0:0] REG_WAVENUMBER = 1'b0;
    localparam logic [0:0] REG_ORDER      = 1'b1;

    typedef enum logic [3:0] {
        OP_TURNS,
        OP_TH,
        OP_T2,
        OP_SIN,
        OP_COS,
        OP_SV,
        OP_RJ0,
        OP_RJ1,
        OP_RJN,
        OP_SP,
        OP_SH,
        OP_SK
    } op_t;

    typedef struct packed {
        logic        [63:0] x32;
        logic signed [3:0]  order;
        logic               last;
        logic        [62:0] rcp;
        logic        [63:0] ang;
        logic        [63:0] th;
        logic        [63:0] t2;
        logic        [63:0] hs;
        logic        [63:0] hc;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] jm;
        logic signed [63:0] jn;
        logic        [63:0] t;
        logic        [63:0] h;
        logic signed [63:0] sum;
    } ctx_t;

    function automatic op_t step_op(int i);
        op_t op;
        if (i == 0)       op = OP_TURNS;
        else if (i == 1)  op = OP_TH;
        else if (i == 2)  op = OP_T2;
        else if (i < 12)  op = OP_SIN;
        else if (i < 22)  op = OP_COS;
        else if (i == 22) op = OP_SV;
        else if (i == 23) op = OP_RJ0;
        else if (i == 24) op = OP_RJ1;
        else if (i < 30)  op = OP_RJN;
        else if (i < 36)  op = OP_SP;
        else if (i == 36) op = OP_SH;
        else              op = OP_SK;
        return op;
    endfunction

    function automatic int step_k(int i);
        int k;
        if (i < 3)        k = 1;
        else if (i < 12)  k = 9 - (i - 3);
        else if (i < 22)  k = 10 - (i - 12);
        else if (i < 25)  k = 1;
        else if (i < 30)  k = i - 24;
        else if (i < 36)  k = i - 29;
        else if (i == 36) k = 1;
        else              k = i - 36;
        return k;
    endfunction

    function automatic int div_of(op_t op, int k, int l);
        int d;
        d = 1;
        case (op)
            OP_SIN:  d = 2 * k * (2 * k + 1);
            OP_COS:  d = (2 * k - 1) * 2 * k;
            OP_SP:   d = 2 * k + 1;
            OP_SK:
            begin
                if (l >= 0 && l <= 6)
                begin
                    d = k * (2 * l + 2 * k + 1);
                end
            end
            default: d = 1;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/spherical_bessel_low_order_unit.sv =====
// Spherical Bessel evaluator j_l(q*r) for orders -1 to 6, fully pipelined.
// One grid point is taken every cycle unless a result waits at the output. An
// input register holds x = q*r, the two-bit-per-stage reciprocal divider forms
// 1/x, 67 update steps (a split 64x64 multiply, a reciprocal multiply for the
// constant divisor and a writeback) build the sine/cosine polynomials, the
// upward recurrence and the 30-term power series, and the output registers
// select, round and saturate the result. Every item walks all steps, so latency
// is fixed whatever the order or argument. The pipeline stops as a whole while a
// result waits at the output. Configuration writes are always taken and must
// only be made while no point is in flight.
module spherical_bessel_low_order_unit
    import sbl_pkg::*;
#(
    parameter int INPUT_FRAC_BITS  = IN_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = RES_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // radius
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // bessel_value
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    logic              en;
    logic [23:0]       wavenumber_reg;
    logic signed [3:0] order_reg;
    logic [47:0]       prod;
    logic [63:0]       x32;
    ctx_t              ctx0_next;
    ctx_t              ctx0_reg;
    logic              v0_reg;
    ctx_t              st_ctx [NUM_STEPS+1];
    logic [NUM_STEPS:0] st_valid;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wavenumber_reg <= '0;
            order_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAVENUMBER: wavenumber_reg <= cfg_data;
                REG_ORDER:      order_reg      <= cfg_data[3:0];
                default:        order_reg      <= order_reg;
            endcase
        end
    end

    assign prod = 48'(s_axis_tdata) * 48'(wavenumber_reg);

    generate
        if (2 * INPUT_FRAC_BITS >= 32)
        begin : g_x_down
            assign x32 = 64'(prod >> (2 * INPUT_FRAC_BITS - 32));
        end
        else
        begin : g_x_up
            assign x32 = 64'(prod) << (32 - 2 * INPUT_FRAC_BITS);
        end
    endgenerate

    always_comb
    begin
        ctx0_next       = '0;
        ctx0_next.x32   = x32;
        ctx0_next.order = order_reg;
        ctx0_next.last  = s_axis_tlast;
        ctx0_next.t     = ONE_Q60;
        ctx0_next.hs    = ONE_Q60;
        ctx0_next.hc    = ONE_Q60;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx0_reg <= ctx0_next;
        end
    end

    sbl_rcp u_rcp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_ctx    (ctx0_reg),
        .out_valid (st_valid[0]),
        .out_ctx   (st_ctx[0])
    );

    genvar i;
    generate
        for (i = 0; i < NUM_STEPS; i++)
        begin : g_step
            sbl_step #(
                .OP (step_op(i)),
                .K  (step_k(i))
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (st_valid[i]),
                .in_ctx    (st_ctx[i]),
                .out_valid (st_valid[i+1]),
                .out_ctx   (st_ctx[i+1])
            );
        end
    endgenerate

    sbl_emit #(
        .RES_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (st_valid[NUM_STEPS]),
        .in_ctx     (st_ctx[NUM_STEPS]),
        .out_valid  (m_axis_tvalid),
        .out_value  (m_axis_tdata),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

// ===== rtl/core/sbl_rcp.sv =====
// pipelined restoring divider forming floor(2^92 / x) in q.60
module sbl_rcp
    import sbl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  ctx_t in_ctx,
    output logic out_valid,
    output ctx_t out_ctx
);

    logic [64:0]           rem_reg [RCP_STAGES];
    logic [62:0]           q_reg   [RCP_STAGES];
    ctx_t                  ctx_reg [RCP_STAGES];
    logic [RCP_STAGES-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RCP_STAGES-2:0], in_valid};
        end
    end

    genvar g;
    generate
        for (g = 0; g < RCP_STAGES; g++)
        begin : g_stage
            logic [64:0] rem_in;
            logic [62:0] q_in;
            ctx_t        ctx_in;
            logic [64:0] rem_next;
            logic [62:0] q_next;

            if (g == 0)
            begin : g_first
                assign rem_in = '0;
                assign q_in   = '0;
                assign ctx_in = in_ctx;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign q_in   = q_reg[g-1];
                assign ctx_in = ctx_reg[g-1];
            end

            always_comb
            begin
                rem_next = rem_in;
                q_next   = q_in;
                for (int j = 0; j < RCP_PER_STAGE; j++)
                begin
                    if (g * RCP_PER_STAGE + j < RCP_STEPS)
                    begin
                        rem_next = {rem_next[63:0], 1'((g * RCP_PER_STAGE + j) == 0)};
                        q_next   = {q_next[61:0], 1'b0};
                        if (rem_next >= {1'b0, ctx_in.x32})
                        begin
                            rem_next  = rem_next - {1'b0, ctx_in.x32};
                            q_next[0] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next;
                    q_reg[g]   <= q_next;
                    ctx_reg[g] <= ctx_in;
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_ctx     = ctx_reg[RCP_STAGES-1];
        out_ctx.rcp = q_reg[RCP_STAGES-1];
    end

    assign out_valid = v_reg[RCP_STAGES-1];

endmodule

// ===== rtl/core/sbl_step.sv =====
// one pipelined multiply, divide-by-constant and update step of the evaluator
module sbl_step
    import sbl_pkg::*;
#(
    parameter op_t OP = OP_TURNS,
    parameter int  K  = 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  ctx_t in_ctx,
    output logic out_valid,
    output ctx_t out_ctx
);

    localparam logic signed [3:0] K_ORD = 4'(K);
    localparam logic [63:0]       K_MUL = 64'(2 * K + 1);

    logic [63:0] m_tab  [16];
    logic [3:0]  sh_tab [16];
    logic [11:0] d_tab  [16];
    logic [15:0] pw_tab;

    genvar gl;
    generate
        for (gl = 0; gl < 16; gl++)
        begin : g_tab
            localparam int LV  = (gl < 8) ? gl : gl - 16;
            localparam int DV  = div_of(OP, K, LV);
            localparam int SHV = $clog2(DV + 1) - 1;
            localparam logic [127:0] MV = (128'd1 << (SHV + 64)) / 128'(DV);
            assign m_tab[gl]  = MV[63:0];
            assign sh_tab[gl] = 4'(SHV);
            assign d_tab[gl]  = 12'(DV);
            assign pw_tab[gl] = ((DV & (DV - 1)) == 0);
        end
    endgenerate

    logic [5:0] v_reg;

    // stage registers
    logic [63:0] s1_ll, s1_lh, s1_hl, s1_hh;
    logic        s1_neg, s2_neg, s3_neg, s4_neg, s5_neg;
    logic [63:0] s1_m, s2_m;
    logic [3:0]  s1_sh, s2_sh, s3_sh, s4_sh;
    logic [11:0] s1_d, s2_d, s3_d, s4_d;
    logic        s1_pw, s2_pw, s3_pw, s4_pw;
    ctx_t        s1_ctx, s2_ctx, s3_ctx, s4_ctx, s5_ctx, s6_ctx;
    logic [63:0] s2_n, s3_n, s4_n;
    logic [63:0] s3_ll, s3_lh, s3_hl, s3_hh;
    logic [63:0] s4_q, s5_q;

    logic [63:0]        a_op, b_op, x60, g64;
    logic signed [63:0] sgn_val;
    logic               neg_op;
    logic [3:0]         tab_idx;
    logic [127:0]       p1, p2, p2_sh;
    logic [63:0]        n_next, q_est, q_corr, r_val;
    logic [63:0]        sres, jp, sa, ca;
    ctx_t               wb;

    assign tab_idx = in_ctx.order;

    // operand selection
    always_comb
    begin
        x60     = {in_ctx.x32[35:0], 28'd0};
        g64     = in_ctx.ang[61] ? (64'h4000_0000_0000_0000 - {2'b00, in_ctx.ang[61:0]})
                                 : {2'b00, in_ctx.ang[61:0]};
        sgn_val = in_ctx.jn;
        neg_op  = 1'b0;
        a_op    = '0;
        b_op    = '0;
        case (OP)
            OP_TURNS:
            begin
                a_op = in_ctx.x32;
                b_op = INV_TWO_PI_Q64;
            end
            OP_TH:
            begin
                a_op = g64;
                b_op = HALF_PI_Q62;
            end
            OP_T2:
            begin
                a_op = in_ctx.th;
                b_op = in_ctx.th;
            end
            OP_SIN:
            begin
                a_op = in_ctx.t2;
                b_op = in_ctx.hs;
            end
            OP_COS:
            begin
                a_op = in_ctx.t2;
                b_op = in_ctx.hc;
            end
            OP_SV:
            begin
                a_op = in_ctx.th;
                b_op = in_ctx.hs;
            end
            OP_RJ0, OP_RJ1, OP_RJN:
            begin
                if (OP == OP_RJ0)
                begin
                    sgn_val = (in_ctx.order == -4'sd1) ? in_ctx.c : in_ctx.s;
                end
                else if (OP == OP_RJ1)
                begin
                    sgn_val = in_ctx.jm - in_ctx.c;
                end
                neg_op = sgn_val[63];
                a_op   = neg_op ? (64'd0 - sgn_val) : sgn_val;
                b_op   = {1'b0, in_ctx.rcp};
            end
            OP_SP:
            begin
                a_op = in_ctx.t;
                b_op = x60;
            end
            OP_SH:
            begin
                a_op = x60;
                b_op = x60;
            end
            OP_SK:
            begin
                a_op = in_ctx.t;
                b_op = in_ctx.h;
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // product sum and slice
    always_comb
    begin
        p1 = {64'd0, s1_ll} + ({64'd0, s1_lh} << 32) + ({64'd0, s1_hl} << 32)
           + {s1_hh, 64'd0};
        case (OP)
            OP_TURNS: n_next = p1[95:32];
            OP_TH:    n_next = p1[127:64];
            default:  n_next = p1[123:60];
        endcase
        if (OP == OP_RJ0 || OP == OP_RJ1 || OP == OP_RJN)
        begin
            n_next[63] = 1'b0;
        end
    end

    // quotient estimate and correction
    always_comb
    begin
        p2     = {64'd0, s3_ll} + ({64'd0, s3_lh} << 32) + ({64'd0, s3_hl} << 32)
               + {s3_hh, 64'd0};
        p2_sh  = p2 >> s3_sh;
        q_est  = p2_sh[127:64];
        r_val  = s4_n - 64'(s4_q * {52'd0, s4_d});
        if (s4_pw)
        begin
            q_corr = s4_n >> s4_sh;
        end
        else if (r_val >= {52'd0, s4_d})
        begin
            q_corr = s4_q + 64'd1;
        end
        else
        begin
            q_corr = s4_q;
        end
    end

    // writeback
    always_comb
    begin
        wb   = s5_ctx;
        sres = s5_neg ? (64'd0 - s5_q) : s5_q;
        jp   = 64'(sres * K_MUL) - s5_ctx.jm;
        sa   = s5_ctx.ang[61] ? s5_ctx.hc : s5_q;
        ca   = s5_ctx.ang[61] ? s5_q : s5_ctx.hc;
        case (OP)
            OP_TURNS: wb.ang = s5_q;
            OP_TH:    wb.th  = s5_q;
            OP_T2:    wb.t2  = s5_q;
            OP_SIN:   wb.hs  = ONE_Q60 - s5_q;
            OP_COS:   wb.hc  = ONE_Q60 - s5_q;
            OP_SV:
            begin
                case (s5_ctx.ang[63:62])
                    2'd0:
                    begin
                        wb.s = sa;
                        wb.c = ca;
                    end
                    2'd1:
                    begin
                        wb.s = ca;
                        wb.c = 64'd0 - sa;
                    end
                    2'd2:
                    begin
                        wb.s = 64'd0 - sa;
                        wb.c = 64'd0 - ca;
                    end
                    default:
                    begin
                        wb.s = 64'd0 - ca;
                        wb.c = sa;
                    end
                endcase
            end
            OP_RJ0:   wb.jm = sres;
            OP_RJ1:   wb.jn = sres;
            OP_RJN:
            begin
                if (s5_ctx.order > K_ORD)
                begin
                    wb.jm = s5_ctx.jn;
                    wb.jn = jp;
                end
            end
            OP_SP:
            begin
                if (s5_ctx.order >= K_ORD)
                begin
                    wb.t = s5_q;
                end
            end
            OP_SH:
            begin
                wb.h   = s5_q >> 1;
                wb.sum = s5_ctx.t;
            end
            OP_SK:
            begin
                wb.t   = s5_q;
                wb.sum = (K % 2 == 1) ? (s5_ctx.sum - s5_q) : (s5_ctx.sum + s5_q);
            end
            default:  wb = s5_ctx;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ll  <= 64'(a_op[31:0])  * 64'(b_op[31:0]);
            s1_lh  <= 64'(a_op[31:0])  * 64'(b_op[63:32]);
            s1_hl  <= 64'(a_op[63:32]) * 64'(b_op[31:0]);
            s1_hh  <= 64'(a_op[63:32]) * 64'(b_op[63:32]);
            s1_neg <= neg_op;
            s1_m   <= m_tab[tab_idx];
            s1_sh  <= sh_tab[tab_idx];
            s1_d   <= d_tab[tab_idx];
            s1_pw  <= pw_tab[tab_idx];
            s1_ctx <= in_ctx;

            s2_n   <= n_next;
            s2_neg <= s1_neg;
            s2_m   <= s1_m;
            s2_sh  <= s1_sh;
            s2_d   <= s1_d;
            s2_pw  <= s1_pw;
            s2_ctx <= s1_ctx;

            s3_ll  <= 64'(s2_n[31:0])  * 64'(s2_m[31:0]);
            s3_lh  <= 64'(s2_n[31:0])  * 64'(s2_m[63:32]);
            s3_hl  <= 64'(s2_n[63:32]) * 64'(s2_m[31:0]);
            s3_hh  <= 64'(s2_n[63:32]) * 64'(s2_m[63:32]);
            s3_n   <= s2_n;
            s3_neg <= s2_neg;
            s3_sh  <= s2_sh;
            s3_d   <= s2_d;
            s3_pw  <= s2_pw;
            s3_ctx <= s2_ctx;

            s4_q   <= q_est;
            s4_n   <= s3_n;
            s4_neg <= s3_neg;
            s4_sh  <= s3_sh;
            s4_d   <= s3_d;
            s4_pw  <= s3_pw;
            s4_ctx <= s3_ctx;

            s5_q   <= q_corr;
            s5_neg <= s4_neg;
            s5_ctx <= s4_ctx;

            s6_ctx <= wb;
        end
    end

    assign out_valid = v_reg[5];
    assign out_ctx   = s6_ctx;

endmodule

// ===== rtl/core/sbl_emit.sv =====
// result selection, rounding and saturation into the output registers
module sbl_emit
    import sbl_pkg::*;
#(
    parameter int RES_FRAC_BITS = RES_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        in_ctx,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic [1:0]  out_status,
    output logic        out_last
);

    localparam int          RND_SH  = 60 - RES_FRAC_BITS;
    localparam logic [63:0] RND_ADD = 64'd1 << (RND_SH - 1);

    logic        a_valid_reg;
    logic [63:0] a_val_reg;
    logic [1:0]  a_st_reg;
    logic        a_last_reg;
    logic        b_valid_reg;
    logic [31:0] b_val_reg;
    logic [1:0]  b_st_reg;
    logic        b_last_reg;

    logic [63:0] sel_val;
    logic [1:0]  sel_st;
    logic [63:0] mag, mag_r, res;
    logic [1:0]  res_st;
    logic        neg;

    always_comb
    begin
        sel_val = '0;
        sel_st  = ST_OK;
        if (in_ctx.order < -4'sd1 || in_ctx.order > 4'sd6)
        begin
            sel_val = '0;
        end
        else if (in_ctx.x32 < X_ZERO_LIMIT)
        begin
            if (in_ctx.order == -4'sd1)
            begin
                sel_st = ST_UNDEF;
            end
            else if (in_ctx.order == 4'sd0)
            begin
                sel_val = ONE_Q60;
            end
        end
        else if (in_ctx.order == -4'sd1)
        begin
            sel_val = (in_ctx.x32 <= X_RECIP_MIN) ? FOUR_Q60 : in_ctx.jm;
        end
        else if ((in_ctx.order == 4'sd5 && in_ctx.x32 < X_CUT5)
              || (in_ctx.order == 4'sd6 && in_ctx.x32 < X_CUT6))
        begin
            sel_val = '0;
        end
        else if (in_ctx.x32 < X_SERIES_LIMIT)
        begin
            sel_val = in_ctx.sum;
        end
        else
        begin
            sel_val = (in_ctx.order == 4'sd0) ? in_ctx.jm : in_ctx.jn;
        end
    end

    always_comb
    begin
        neg    = a_val_reg[63];
        mag    = neg ? (64'd0 - a_val_reg) : a_val_reg;
        mag_r  = (mag + RND_ADD) >> RND_SH;
        res_st = a_st_reg;
        if (!neg && mag_r > 64'h7FFF_FFFF)
        begin
            mag_r  = 64'h7FFF_FFFF;
            res_st = ST_SAT;
        end
        if (neg && mag_r > 64'h8000_0000)
        begin
            mag_r  = 64'h8000_0000;
            res_st = ST_SAT;
        end
        res = neg ? (64'd0 - mag_r) : mag_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_val_reg  <= sel_val;
            a_st_reg   <= sel_st;
            a_last_reg <= in_ctx.last;
            b_val_reg  <= res[31:0];
            b_st_reg   <= res_st;
            b_last_reg <= a_last_reg;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_value  = b_val_reg;
    assign out_status = b_st_reg;
    assign out_last   = b_last_reg;

endmodule

// ===== rtl/core/sbl_checker.sv =====
// port-level checks for the spherical bessel unit and their binding
`include "spherical_bessel_low_order_unit_defines.svh"

module sbl_checker
    import sbl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result holds
    `SBL_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // undefined status carries a zero value
    `SBL_ASSERT_IMP(a_undef_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ST_UNDEF), m_axis_tdata == 32'd0)

    // saturation flag only at a range limit
    `SBL_ASSERT_IMP(a_sat_limit, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ST_SAT), (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))

    // input only held off by a waiting result
    `SBL_ASSERT_IMP(a_ready_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind spherical_bessel_low_order_unit sbl_checker u_sbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
